/* sv/usd_pkg.sv */
// Shared types, constants and range tables for the UTF-8 stream decoder.
package usd_pkg;

    localparam int MAX_SEQUENCE_BYTES = 4;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int GLYPH_W = 16;

    localparam logic [CP_W-1:0]    REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0]    SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0]    SURR_HI     = 21'h00DFFF;
    localparam logic [GLYPH_W-1:0] GLYPH_MAX   = 16'hFFFF;

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } byte_beat_t;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [LEN_W-1:0]   bytes_used;
        logic [1:0]         status;
        logic [GLYPH_W-1:0] glyph_number;
        logic               run_last;
    } glyph_beat_t;

    typedef struct packed {
        logic [1:0]  count;
        glyph_beat_t first;
        glyph_beat_t second;
    } dec_result_t;

    typedef struct packed {
        logic seq_open;
        logic counter_zero;
    } dec_status_t;

    function automatic logic [CP_W-1:0] min_for_len(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] v;
        case (len)
            3'd2:    v = 21'h000080;
            3'd3:    v = 21'h000800;
            3'd4:    v = 21'h010000;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

    function automatic logic [CP_W-1:0] max_for_len(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] v;
        case (len)
            3'd1:    v = 21'h00007F;
            3'd2:    v = 21'h0007FF;
            3'd3:    v = 21'h00FFFF;
            3'd4:    v = 21'h10FFFF;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

/* sv/usd_decode.sv */
// Sequence state and per-byte decode: produces up to two glyph results per byte.
module usd_decode
    import usd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  byte_beat_t  beat,
    output dec_result_t result,
    output dec_status_t stat
);

    logic [LEN_W-1:0]   exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]   taken_reg, taken_next;
    logic [CP_W-1:0]    partial_reg, partial_next;
    logic [GLYPH_W-1:0] counter_reg, counter_next;

    logic [7:0]         b;
    logic               is_cont;
    logic               seq_open;
    logic               lead_ascii;
    logic               lead_bad;
    logic [LEN_W-1:0]   lead_len;
    logic [CP_W-1:0]    lead_bits;
    logic [CP_W-1:0]    ext_part;
    logic [LEN_W-1:0]   taken_inc;
    logic               bad;
    logic               a_v, b_v, c_v;
    glyph_beat_t        ba, bb, bc;
    logic [GLYPH_W-1:0] gb, gc;
    logic [1:0]         cnt;

    function automatic logic [GLYPH_W-1:0] sat_inc(input logic [GLYPH_W-1:0] g);
        return (g == GLYPH_MAX) ? g : g + GLYPH_W'(1);
    endfunction

    always_comb
    begin
        b          = beat.text_byte;
        is_cont    = (b[7:6] == 2'b10);
        seq_open   = (exp_len_reg != '0);
        lead_ascii = !b[7];
        lead_bad   = is_cont || (b[7:3] == 5'b11111);
        if (b[7:5] == 3'b110)
        begin
            lead_len  = 3'd2;
            lead_bits = {16'b0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            lead_len  = 3'd3;
            lead_bits = {17'b0, b[3:0]};
        end
        else
        begin
            lead_len  = 3'd4;
            lead_bits = {18'b0, b[2:0]};
        end
        ext_part  = {partial_reg[CP_W-7:0], b[5:0]};
        taken_inc = taken_reg + LEN_W'(1);
        bad       = 1'b0;

        a_v = 1'b0;
        b_v = 1'b0;
        c_v = 1'b0;
        ba  = '0;
        bb  = '0;
        bc  = '0;

        exp_len_next = exp_len_reg;
        taken_next   = taken_reg;
        partial_next = partial_reg;

        // broken sequence: flush what was taken, then treat byte as a lead
        if (seq_open && !is_cont)
        begin
            a_v           = 1'b1;
            ba.code_point = REPLACEMENT;
            ba.bytes_used = taken_reg;
            ba.status     = ST_INVALID;
            exp_len_next  = '0;
            taken_next    = '0;
            partial_next  = '0;
        end

        if (!seq_open || !is_cont)
        begin
            if (lead_ascii)
            begin
                b_v           = 1'b1;
                bb.code_point = {13'b0, b};
                bb.bytes_used = 3'd1;
                bb.status     = ST_VALID;
            end
            else if (lead_bad)
            begin
                b_v           = 1'b1;
                bb.code_point = REPLACEMENT;
                bb.bytes_used = 3'd1;
                bb.status     = ST_INVALID;
            end
            else
            begin
                exp_len_next = lead_len;
                taken_next   = 3'd1;
                partial_next = lead_bits;
            end
        end
        else
        begin
            partial_next = ext_part;
            taken_next   = taken_inc;
            if (taken_inc >= exp_len_reg)
            begin
                bad = (ext_part < min_for_len(exp_len_reg))
                   || (ext_part > max_for_len(exp_len_reg))
                   || ((ext_part >= SURR_LO) && (ext_part <= SURR_HI));
                b_v           = 1'b1;
                bb.code_point = bad ? REPLACEMENT : ext_part;
                bb.bytes_used = exp_len_reg;
                bb.status     = bad ? ST_INVALID : ST_VALID;
                exp_len_next  = '0;
                taken_next    = '0;
                partial_next  = '0;
            end
        end

        if (beat.end_of_text)
        begin
            c_v           = (exp_len_next != '0);
            bc.code_point = REPLACEMENT;
            bc.bytes_used = '0;
            bc.status     = ST_TRUNCATED;
            exp_len_next  = '0;
            taken_next    = '0;
            partial_next  = '0;
        end

        // glyph numbering; truncation never advances the count
        ba.glyph_number = counter_reg;
        gb              = a_v ? sat_inc(counter_reg) : counter_reg;
        bb.glyph_number = gb;
        gc              = b_v ? sat_inc(gb) : gb;
        bc.glyph_number = gc;
        counter_next    = beat.end_of_text ? '0 : gc;

        cnt = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};
        result.count  = cnt;
        result.first  = a_v ? ba : (b_v ? bb : bc);
        result.second = (a_v && b_v) ? bb : bc;
        if (cnt == 2'd1)
        begin
            result.first.run_last = 1'b1;
        end
        if (cnt == 2'd2)
        begin
            result.second.run_last = 1'b1;
        end

        stat.seq_open     = seq_open;
        stat.counter_zero = (counter_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= '0;
            taken_reg   <= '0;
            partial_reg <= '0;
            counter_reg <= '0;
        end
        else if (fire)
        begin
            exp_len_reg <= exp_len_next;
            taken_reg   <= taken_next;
            partial_reg <= partial_next;
            counter_reg <= counter_next;
        end
    end

endmodule

/* sv/usd_glyph_queue.sv */
// Small queue: up to two glyph beats in per cycle, one out unless stalled.
module usd_glyph_queue
    import usd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_count,
    input  glyph_beat_t push_first,
    input  glyph_beat_t push_second,
    output logic        room,
    output logic        glyph_valid,
    input  logic        glyph_stall,
    output glyph_beat_t glyph_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    glyph_beat_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        pop         = glyph_valid && !glyph_stall;
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push_count == 2'd1)
        begin
            wr_ptr_next = wr_ptr_inc;
        end
        else if (push_count == 2'd2)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    assign glyph_valid = (count_reg != '0);
    assign glyph_data  = mem_reg[rd_ptr_reg];
    // a decoded byte may yield two beats
    assign room        = (count_reg <= CNT_W'(DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/utf8_stream_decoder.sv */
// UTF-8 stream decoder top level: input register, decode stage, result queue.
//
//   channel  beat          handshake                  payload
//   byte     byte_beat_t   byte_valid / byte_stall    byte_data
//   glyph    glyph_beat_t  glyph_valid / glyph_stall  glyph_data
//
// One byte per cycle is taken while byte_stall is low; a byte is decoded
// from the input register. A byte gives zero, one or two glyph beats; the
// glyph side drains one beat per cycle while glyph_stall is low, so
// sustained rate is one byte per cycle while bytes average at most one
// glyph. byte_stall rises when a byte waits and the queue cannot hold two
// more beats. Reset clears the open sequence, the glyph counter and queue.
module utf8_stream_decoder
    import usd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_beat_t  byte_data,
    output logic        glyph_valid,
    input  logic        glyph_stall,
    output glyph_beat_t glyph_data
);

    logic        in_valid_reg, in_valid_next;
    byte_beat_t  in_beat_reg;
    logic        room;
    logic        fire;
    logic        accept;
    logic [1:0]  push_count;
    dec_result_t dec_res;
    dec_status_t dec_stat;

    assign fire       = in_valid_reg && room;
    assign byte_stall = in_valid_reg && !room;
    assign accept     = byte_valid && !byte_stall;
    assign push_count = fire ? dec_res.count : 2'd0;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_beat_reg <= byte_data;
        end
    end

    usd_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .beat   (in_beat_reg),
        .result (dec_res),
        .stat   (dec_stat)
    );

    usd_glyph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (dec_res.first),
        .push_second (dec_res.second),
        .room        (room),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph_data  (glyph_data)
    );

    // run_last marks exactly the final beat of a byte
    a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && dec_res.count == 2'd2) |->
            (!dec_res.first.run_last && dec_res.second.run_last))
        else $error("run_last misplaced on two-beat byte");

    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && dec_res.count == 2'd1) |-> dec_res.first.run_last)
        else $error("run_last missing on single-beat byte");

    // end of text closes the sequence and restarts glyph numbering
    a_eot_close: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_beat_reg.end_of_text) |=>
            (!dec_stat.seq_open && dec_stat.counter_zero))
        else $error("end of text left state behind");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(glyph_valid) |-> $past(!glyph_stall))
        else $error("glyph beat withdrawn without handshake");

endmodule
